// ----- hw/rtl/epd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package epd_pkg;

  // Field widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned StartW   = 24;
  localparam int unsigned StepW    = 16;
  localparam int unsigned DistW    = 16;
  localparam int unsigned IndexW   = 11;
  localparam int unsigned PeakNumW = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Frame limits
  localparam int unsigned MaxSamples = 2048;
  localparam int unsigned MaxPeaks   = 1024;
  localparam int unsigned SeenW      = $clog2(MaxPeaks + 1);

  // Distance arithmetic: um = start + idx * step stays below 2^28
  localparam int unsigned UmW       = 28;
  localparam int unsigned UmPerMm   = 1000;
  localparam int unsigned RecipSh   = 28;
  localparam int unsigned RecipW    = 19;
  // floor(2^28 / 1000): quotient estimate is exact or one low for um < 2^28
  localparam logic [RecipW-1:0] Recip = RecipW'(268435);
  localparam int unsigned QuotW     = 18;
  localparam int unsigned RemW      = 11;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegStartUm   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegStepUm    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegOffsetMm  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAmpThresh = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRangeLim  = 3'd4;

  typedef struct packed {
    logic [StartW-1:0]  start_um;
    logic [StepW-1:0]   step_um;
    logic [DistW-1:0]   offset_mm;
    logic [SampleW-1:0] amplitude_threshold;
    logic [DistW-1:0]   range_limit_mm;
  } cfg_t;

  typedef struct packed {
    logic [SampleW-1:0]  amplitude;
    logic [IndexW-1:0]   sample_index;
    logic [PeakNumW-1:0] peak_number;
  } peak_t;

  typedef struct packed {
    logic [DistW-1:0]    distance_mm;
    logic [SampleW-1:0]  amplitude;
    logic [IndexW-1:0]   sample_index;
    logic [PeakNumW-1:0] peak_number;
    logic                passes_filter;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/epd_detect.sv -----
`timescale 1ns / 1ps
`default_nettype none

module epd_detect (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_valid_i,
  output logic                            s_ready_o,
  input  wire logic [epd_pkg::SampleW-1:0] sample_i,
  input  wire logic                       last_i,
  output logic                            pk_valid_o,
  input  wire logic                       pk_ready_i,
  output epd_pkg::peak_t                  pk_o
);
  import epd_pkg::*;

  logic [SampleW-1:0] before_q, before_d;
  logic [SampleW-1:0] held_q, held_d;
  logic [SampleW-1:0] plat_q, plat_d;
  logic [IndexW-1:0]  pos_q, pos_d;
  logic [SeenW-1:0]   seen_q, seen_d;
  logic               overrun_q, overrun_d;
  logic               pk_v_q, pk_v_d;
  peak_t              pk_q, pk_d;

  logic accept;
  logic is_peak;
  logic emit;

  assign s_ready_o  = !pk_v_q || pk_ready_i;
  assign accept     = s_valid_i && s_ready_o;
  assign pk_valid_o = pk_v_q;
  assign pk_o       = pk_q;

  assign is_peak = (held_q > sample_i) && ((held_q > before_q) || (held_q == plat_q));
  assign emit    = accept && !overrun_q && (pos_q[IndexW-1:1] != '0) && is_peak &&
                   (seen_q < SeenW'(MaxPeaks));

  always_comb begin
    before_d  = before_q;
    held_d    = held_q;
    plat_d    = plat_q;
    pos_d     = pos_q;
    seen_d    = seen_q;
    overrun_d = overrun_q;
    pk_v_d    = pk_v_q && !pk_ready_i;
    pk_d      = pk_q;

    if (emit) begin
      pk_v_d           = 1'b1;
      pk_d.amplitude    = held_q;
      pk_d.sample_index = pos_q - IndexW'(1);
      pk_d.peak_number  = seen_q[PeakNumW-1:0];
      seen_d           = seen_q + SeenW'(1);
    end

    if (accept && !overrun_q) begin
      // plateau tracking for the held sample, after its own peak test
      if (pos_q[IndexW-1:1] != '0) begin
        if (held_q > plat_q && held_q > before_q) begin
          plat_d = held_q;
        end else if (held_q < before_q) begin
          plat_d = '0;
        end
      end
      before_d = held_q;
      held_d   = sample_i;
      if (pos_q == IndexW'(MaxSamples - 1)) begin
        overrun_d = 1'b1;
      end else begin
        pos_d = pos_q + IndexW'(1);
      end
    end

    // end of frame wipes the whole frame state
    if (accept && last_i) begin
      before_d  = '0;
      held_d    = '0;
      plat_d    = '0;
      pos_d     = '0;
      seen_d    = '0;
      overrun_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      before_q  <= '0;
      held_q    <= '0;
      plat_q    <= '0;
      pos_q     <= '0;
      seen_q    <= '0;
      overrun_q <= 1'b0;
      pk_v_q    <= 1'b0;
    end else begin
      before_q  <= before_d;
      held_q    <= held_d;
      plat_q    <= plat_d;
      pos_q     <= pos_d;
      seen_q    <= seen_d;
      overrun_q <= overrun_d;
      pk_v_q    <= pk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pk_q <= pk_d;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/epd_distance.sv -----
`timescale 1ns / 1ps
`default_nettype none

module epd_distance (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire epd_pkg::cfg_t cfg_i,
  input  wire logic       pk_valid_i,
  output logic            pk_ready_o,
  input  wire epd_pkg::peak_t pk_i,
  output logic            m_valid_o,
  input  wire logic       m_ready_i,
  output epd_pkg::result_t res_o
);
  import epd_pkg::*;

  localparam int unsigned MulW  = IndexW + StepW;
  localparam int unsigned ProdW = UmW + RecipW;

  // stage a: micrometres
  logic               a_v_q;
  peak_t              a_pk_q;
  logic [UmW-1:0]     a_um_q, a_um_d;
  logic [MulW-1:0]    a_mul;
  // stage b: quotient estimate
  logic               b_v_q;
  peak_t              b_pk_q;
  logic [UmW-1:0]     b_um_q;
  logic [QuotW-1:0]   b_q0_q, b_q0_d;
  logic [ProdW-1:0]   b_prod;
  // stage c: corrected millimetres
  logic               c_v_q;
  peak_t              c_pk_q;
  logic [QuotW-1:0]   c_mm_q, c_mm_d;
  logic [UmW-1:0]     c_back;
  logic [RemW-1:0]    c_rem;
  // output stage
  logic               o_v_q;
  result_t            o_res_q, o_res_d;
  logic [QuotW-1:0]   o_diff;

  logic a_rdy, b_rdy, c_rdy, o_rdy;

  assign o_rdy      = !o_v_q || m_ready_i;
  assign c_rdy      = !c_v_q || o_rdy;
  assign b_rdy      = !b_v_q || c_rdy;
  assign a_rdy      = !a_v_q || b_rdy;
  assign pk_ready_o = a_rdy;
  assign m_valid_o  = o_v_q;
  assign res_o      = o_res_q;

  assign a_mul  = pk_i.sample_index * cfg_i.step_um;
  assign a_um_d = UmW'(a_mul) + UmW'(cfg_i.start_um);

  assign b_prod = ProdW'(a_um_q) * ProdW'(Recip);
  assign b_q0_d = b_prod[RecipSh +: QuotW];

  assign c_back = UmW'(b_q0_q) * UmW'(UmPerMm);
  assign c_rem  = RemW'(b_um_q - c_back);
  assign c_mm_d = b_q0_q + QuotW'(c_rem >= RemW'(UmPerMm));

  assign o_diff = c_mm_q - QuotW'(cfg_i.offset_mm);

  always_comb begin
    o_res_d              = o_res_q;
    o_res_d.amplitude    = c_pk_q.amplitude;
    o_res_d.sample_index = c_pk_q.sample_index;
    o_res_d.peak_number  = c_pk_q.peak_number;
    if (c_mm_q <= QuotW'(cfg_i.offset_mm)) begin
      o_res_d.distance_mm = '0;
    end else if (o_diff[QuotW-1:DistW] != '0) begin
      o_res_d.distance_mm = '1;
    end else begin
      o_res_d.distance_mm = o_diff[DistW-1:0];
    end
    o_res_d.passes_filter = (c_pk_q.amplitude > cfg_i.amplitude_threshold) &&
                            (o_res_d.distance_mm < cfg_i.range_limit_mm);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= pk_valid_i;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
      if (o_rdy) o_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      a_pk_q <= pk_i;
      a_um_q <= a_um_d;
    end
    if (b_rdy) begin
      b_pk_q <= a_pk_q;
      b_um_q <= a_um_q;
      b_q0_q <= b_q0_d;
    end
    if (c_rdy) begin
      c_pk_q <= b_pk_q;
      c_mm_q <= c_mm_d;
    end
    if (o_rdy) begin
      o_res_q <= o_res_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/envelope_peak_detector_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Envelope peak detector. Envelope samples stream in on the slave side, one
// transaction per sample, tlast on the final sample of a frame. An interior
// sample that is above both neighbors, or sits on the current plateau level
// and is above the next sample, is reported on the master side with its
// distance in mm, amplitude, index, running peak number and a filter flag.
// A sample is taken every cycle unless an unread peak holds the peak register;
// the peak for sample i is decided when sample i+1 arrives and then passes
// five register stages (peak register, multiply, reciprocal divide by 1000,
// correction, output register). The stages stall independently, so samples
// keep flowing while a result waits as long as a free stage remains.
// Configuration is written through a plain write port; the user must write
// it only while no frame is in flight (not enforced). The first and the last
// sample of a frame are never peaks; frames longer than 2048 samples ignore
// the excess until tlast, and at most 1024 peaks are reported per frame.

module envelope_peak_detector_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [epd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [epd_pkg::CfgDataW-1:0] cfg_data_i,
  // sample stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [15:0]                  s_axis_tdata,  // [15:0] sample
  input  wire logic                         s_axis_tlast,  // last sample of frame
  // peak stream
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [15:0] distance_mm, [31:16] amplitude, [42:32] sample_index,
  // [52:43] peak_number, [55:53] zero
  output logic [55:0]                       m_axis_tdata,
  output logic                              m_axis_tuser   // [0] passes_filter
);
  import epd_pkg::*;

  cfg_t    cfg_q;
  peak_t   pk;
  logic    pk_valid;
  logic    pk_ready;
  result_t res;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_um            <= '0;
      cfg_q.step_um             <= StepW'(500);
      cfg_q.offset_mm           <= '0;
      cfg_q.amplitude_threshold <= '0;
      cfg_q.range_limit_mm      <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegStartUm:   cfg_q.start_um            <= cfg_data_i[StartW-1:0];
        RegStepUm:    cfg_q.step_um             <= cfg_data_i[StepW-1:0];
        RegOffsetMm:  cfg_q.offset_mm           <= cfg_data_i[DistW-1:0];
        RegAmpThresh: cfg_q.amplitude_threshold <= cfg_data_i[SampleW-1:0];
        RegRangeLim:  cfg_q.range_limit_mm      <= cfg_data_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  // Frame tracking and peak decision
  epd_detect u_detect (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .sample_i   (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .pk_valid_o (pk_valid),
    .pk_ready_i (pk_ready),
    .pk_o       (pk)
  );

  // Distance conversion, filter flag and output register
  epd_distance u_distance (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .pk_valid_i (pk_valid),
    .pk_ready_o (pk_ready),
    .pk_i       (pk),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {3'b000, res.peak_number, res.sample_index,
                         res.amplitude, res.distance_mm};
  assign m_axis_tuser = res.passes_filter;

endmodule

`default_nettype wire

// ----- tb/sv/envelope_peak_detector_unit_tb.sv -----
`timescale 1ns / 1ps

module envelope_peak_detector_unit_tb;
  import epd_pkg::*;

  localparam int unsigned GapPct       = 34;      // idle / stall odds per hundred
  localparam int unsigned SettleCycles = 16;      // pipeline is five stages deep
  localparam int unsigned CycleLimit   = 400000;  // far above the slowest clean run
  localparam int unsigned MaxReported  = 10;
  localparam int unsigned PhaseItems   = 150;     // random samples per register setting
  localparam int unsigned LongLen      = 300;     // samples in the long frame

  // Shapes of random frames: noise, small steps (plateaus), slow walk, rails.
  typedef enum int unsigned {StyleNoise, StyleSteps, StyleWalk, StyleRails} style_e;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata = '0;   // [15:0] sample
  logic                s_axis_tlast = 1'b0; // last sample of frame
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [15:0] distance_mm, [31:16] amplitude, [42:32] sample_index,
  // [52:43] peak_number, [55:53] zero
  logic [55:0]         m_axis_tdata;
  logic                m_axis_tuser;        // [0] passes_filter

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  envelope_peak_detector_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // ---------------------------------------------------------------------------
  // Peak predictor: shadow registers plus per-frame detector state
  // ---------------------------------------------------------------------------
  logic [StartW-1:0]  cfg_start  = '0;
  logic [StepW-1:0]   cfg_step   = StepW'(500);
  logic [DistW-1:0]   cfg_offset = '0;
  logic [SampleW-1:0] cfg_thresh = '0;
  logic [DistW-1:0]   cfg_range  = '1;

  logic [SampleW-1:0] prev_smp = '0;   // sample i-1
  logic [SampleW-1:0] held_smp = '0;   // sample i, waiting for its right neighbor
  logic [SampleW-1:0] plateau  = '0;
  int unsigned        smp_pos  = 0;    // index of the next incoming sample
  int unsigned        peak_cnt = 0;
  bit                 overrun  = 1'b0; // frame ran past MaxSamples, drop until tlast

  result_t pending_peaks[$];           // predicted peaks not yet seen on the output

  bit          steady = 1'b0;          // no idling on either side while set
  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned samples_in = 0;
  int unsigned frames_in = 0;
  int unsigned peaks_checked = 0;
  int unsigned peaks_passing = 0;

  function automatic logic [DistW-1:0] mm_at_index(int unsigned idx);
    longint unsigned um;
    longint unsigned mm;
    um = 64'(cfg_start) + 64'(idx) * 64'(cfg_step);
    mm = um / UmPerMm;
    if (mm <= 64'(cfg_offset)) return '0;
    mm -= 64'(cfg_offset);
    return (mm > 64'hFFFF) ? '1 : DistW'(mm);
  endfunction

  function automatic void restart_frame();
    prev_smp = '0;
    held_smp = '0;
    plateau  = '0;
    smp_pos  = 0;
    peak_cnt = 0;
    overrun  = 1'b0;
  endfunction

  // Advances the detector by one accepted sample; queues the peak it reveals.
  function automatic void track_sample(logic [SampleW-1:0] smp, logic last);
    result_t            pk;
    logic [SampleW-1:0] h;
    bit                 hit;
    int unsigned        p;
    p = smp_pos;
    if (overrun) begin
      if (last) restart_frame();
      return;
    end
    // index 0 has no left neighbor: no peak test and no plateau update
    if (p >= 2) begin
      h   = held_smp;
      hit = (h > smp) && ((h > prev_smp) || (h == plateau));
      if (hit && peak_cnt < MaxPeaks) begin
        pk.distance_mm   = mm_at_index(p - 1);
        pk.amplitude     = h;
        pk.sample_index  = IndexW'(p - 1);
        pk.peak_number   = PeakNumW'(peak_cnt);
        pk.passes_filter = (h > cfg_thresh) && (pk.distance_mm < cfg_range);
        pending_peaks.push_back(pk);
        peak_cnt++;
      end
      // plateau follows the peak test of the same sample
      if (h > plateau && h > prev_smp) begin
        plateau = h;
      end else if (h < prev_smp) begin
        plateau = '0;
      end
    end
    prev_smp = held_smp;
    held_smp = smp;
    if (last) begin
      restart_frame();
    end else if (p >= MaxSamples - 1) begin
      overrun = 1'b1;
    end else begin
      smp_pos = p + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor and checker: input transactions feed the predictor first, then the
  // output transaction of the same edge is compared with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_sample(s_axis_tdata, s_axis_tlast);
        samples_in++;
        if (s_axis_tlast) frames_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.distance_mm   = m_axis_tdata[15:0];
        got.amplitude     = m_axis_tdata[31:16];
        got.sample_index  = m_axis_tdata[42:32];
        got.peak_number   = m_axis_tdata[52:43];
        got.passes_filter = m_axis_tuser;
        if (pending_peaks.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReported)
            $display("%0t: peak out with none pending: dist %0d amp %0d idx %0d num %0d pass %0b",
                     $realtime, got.distance_mm, got.amplitude, got.sample_index,
                     got.peak_number, got.passes_filter);
        end else begin
          want = pending_peaks.pop_front();
          peaks_checked++;
          if (want.passes_filter) peaks_passing++;
          if (got.distance_mm !== want.distance_mm || got.amplitude !== want.amplitude ||
              got.sample_index !== want.sample_index ||
              got.peak_number !== want.peak_number ||
              got.passes_filter !== want.passes_filter) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MaxReported)
              $display("%0t: peak mismatch exp dist %0d amp %0d idx %0d num %0d pass %0b | got dist %0d amp %0d idx %0d num %0d pass %0b",
                       $realtime, want.distance_mm, want.amplitude, want.sample_index,
                       want.peak_number, want.passes_filter, got.distance_mm, got.amplitude,
                       got.sample_index, got.peak_number, got.passes_filter);
          end
        end
      end
    end
  end

  // Peak sink back-pressure.
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= GapPct);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d peaks pending", cycle_cnt, pending_peaks.size());
      $display("envelope_peak_detector_unit_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drive tasks
  // ---------------------------------------------------------------------------

  // One sample transaction; random idle cycles ahead of it unless steady.
  task automatic send_sample(input logic [SampleW-1:0] smp, input logic last);
    while (!steady && $urandom_range(99) < GapPct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop sending, let every predicted peak come out, then let the pipe settle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all five registers, then the unused indexes with junk (ignored).
  task automatic load_regs(input logic [CfgDataW-1:0] start_v, input logic [CfgDataW-1:0] step_v,
                           input logic [CfgDataW-1:0] offset_v,
                           input logic [CfgDataW-1:0] thresh_v,
                           input logic [CfgDataW-1:0] range_v);
    logic [CfgDataW-1:0] vals[5];
    logic [CfgDataW-1:0] wdata;
    vals = '{start_v, step_v, offset_v, thresh_v, range_v};
    for (int k = 0; k < (1 << CfgIdxW); k++) begin
      wdata = (k < 5) ? vals[k] : CfgDataW'($urandom);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(k);
      cfg_data_i <= wdata;
      @(posedge clk_i);
      case (CfgIdxW'(k))
        RegStartUm:   cfg_start  = wdata[StartW-1:0];
        RegStepUm:    cfg_step   = wdata[StepW-1:0];
        RegOffsetMm:  cfg_offset = wdata[DistW-1:0];
        RegAmpThresh: cfg_thresh = wdata[SampleW-1:0];
        RegRangeLim:  cfg_range  = wdata[DistW-1:0];
        default: ;
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [SampleW-1:0] pick_sample(style_e style, logic [SampleW-1:0] last_v,
                                                     logic [SampleW-1:0] base);
    int v;
    case (style)
      StyleNoise: return SampleW'($urandom);
      StyleSteps: return base + SampleW'($urandom_range(0, 3));
      StyleWalk: begin
        v = int'(last_v) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return SampleW'(v);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'h0001;
          2: return 16'hFFFE;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  // Random frames, each closed by tlast, until n_items samples have gone out.
  // Mostly short frames; a few of one or two samples, a few long ones.
  task automatic run_frames(input int unsigned n_items);
    int unsigned        sent;
    int unsigned        len;
    int unsigned        r;
    style_e             style;
    logic [SampleW-1:0] base;
    logic [SampleW-1:0] smp;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 8)       len = $urandom_range(1, 2);
      else if (r < 13) len = $urandom_range(60, 200);
      else             len = $urandom_range(3, 40);
      style = style_e'($urandom_range(0, 3));
      base  = SampleW'($urandom);
      smp   = base;
      for (int i = 0; i < len; i++) begin
        smp = pick_sample(style, smp, base);
        send_sample(smp, i == len - 1);
      end
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Frames of one and two samples never report.
  task automatic test_short_frames();
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
  endtask

  // First and last index are never peaks; index 1 can be, even when its
  // right neighbor carries tlast.
  task automatic test_frame_edges();
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'd0, 1'b0);
    send_sample(16'd1, 1'b0);
    send_sample(16'd0, 1'b1);
  endtask

  // Flat tops: the end of a plateau reports; a plateau starting at index 0
  // does not (no plateau update there); a fall clears the plateau level.
  task automatic test_plateaus();
    logic [SampleW-1:0] flat_top[5]  = '{16'd1, 16'd5, 16'd5, 16'd5, 16'd2};
    logic [SampleW-1:0] edge_flat[3] = '{16'd5, 16'd5, 16'd2};
    logic [SampleW-1:0] two_tops[7]  = '{16'd2, 16'd9, 16'd9, 16'd4, 16'd9, 16'd9, 16'd1};
    foreach (flat_top[i]) send_sample(flat_top[i], i == 4);
    foreach (edge_flat[i]) send_sample(edge_flat[i], i == 2);
    foreach (two_tops[i]) send_sample(two_tops[i], i == 6);
  endtask

  // Random traffic under a series of register settings, extremes included.
  // Data bits above a 16-bit register's width are set to show they're dropped.
  task automatic test_register_settings();
    run_frames(PhaseItems);                      // reset values
    wait_idle();
    load_regs('1, '1, '1, '1, '1);               // offset swallows all distance
    run_frames(PhaseItems);
    wait_idle();
    load_regs('0, '0, '0, '0, '0);               // zero range: nothing passes
    run_frames(PhaseItems);
    wait_idle();
    load_regs('1, 24'hAB_FFFF, 24'hCD_0000, 24'h12_8000, 24'h00_4470);
    run_frames(PhaseItems);
    wait_idle();
    load_regs(CfgDataW'($urandom), {8'($urandom), 16'($urandom_range(0, 4000))},
              {8'($urandom), 16'($urandom_range(0, 20000))}, CfgDataW'($urandom),
              {8'($urandom), 16'($urandom_range(0, 40000))});
    steady = 1'b1;                               // long stretch with no idling
    run_frames(PhaseItems);
    wait_idle();
    steady = 1'b0;
    load_regs(CfgDataW'($urandom_range(0, 50000)), CfgDataW'($urandom_range(100, 1500)),
              CfgDataW'($urandom_range(0, 30)), CfgDataW'($urandom),
              CfgDataW'($urandom_range(0, 60)));
    run_frames(PhaseItems);
    wait_idle();
  endtask

  // A long frame with a peak at every odd index but the last: peak number
  // and index climb through most of their bits. Then a short frame to show
  // tlast cleared the frame state.
  task automatic test_long_frames();
    load_regs('1, '1, 24'd100, 24'h8000, 24'hC000);
    for (int unsigned i = 0; i < LongLen; i++) begin
      send_sample(i[0] ? SampleW'($urandom_range(200, 65535)) : SampleW'($urandom_range(0, 199)),
                  i == LongLen - 1);
    end
    send_sample(16'd3, 1'b0);
    send_sample(16'd9, 1'b0);
    send_sample(16'd3, 1'b1);
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_frames();
    test_frame_edges();
    test_plateaus();
    test_register_settings();
    test_long_frames();
    wait_idle();

    $display("covered %0d samples in %0d frames, %0d peaks checked (%0d passing the filter)",
             samples_in, frames_in, peaks_checked, peaks_passing);
    $display("settings: reset, all ones, all zeros, near-saturating, random; one long frame");
    if (mismatch_cnt == 0 && pending_peaks.size() == 0) begin
      $display("envelope_peak_detector_unit_tb: clean");
    end else begin
      $display("%0d mismatches, %0d peaks never seen", mismatch_cnt, pending_peaks.size());
      $display("envelope_peak_detector_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/epd_pkg.sv
hw/rtl/epd_detect.sv
hw/rtl/epd_distance.sv
hw/rtl/envelope_peak_detector_unit.sv
tb/sv/envelope_peak_detector_unit_tb.sv
